// ===== sv/mipmap_box_downsampler_defines.svh =====
// assertion helpers for the mipmap box downsampler
`ifndef MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH

// same-cycle implication
`define MBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mipmap downsampler check failed");

// next-cycle implication
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mipmap downsampler check failed");

`endif

// ===== sv/mbd_pkg.sv =====
package mbd_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int LANES        = 4;
	localparam int CFG_W        = 13;
	localparam int ROW_W        = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int CH_W         = 3;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SRC_WIDTH     = 2'd0,
		CFG_SRC_HEIGHT    = 2'd1,
		CFG_CHANNEL_COUNT = 2'd2,
		CFG_WIDE_SAMPLES  = 2'd3
	} cfg_idx_t;

	typedef logic [LANES-1:0][SAMPLE_W-1:0] pix_t;

	// control carried with an item from the line store read stage to the averager
	typedef struct packed {
		logic             last;
		logic             h_one;
		logic             w_one;
		logic [LANES-1:0] lane_en;
	} ctl_t;

endpackage

// ===== sv/mipmap_box_downsampler.sv =====
// 2x2 box-filter mipmap reduction of a raster-order pixel stream. One source pixel is
// accepted per clock, sustained, with stalls only from out_ready; a result passes the
// read stage and output registers. The rate is set by the line store: each item makes
// one read of each of its two banks (even and odd source columns) and at most one write.
// The line store is not cleared after reset and needs no clearing pass; it is always
// written by an even row before an odd row reads it. Write configuration only while the
// block is idle; the block does not enforce it. Counters wrap to zero at each image end.
`include "mipmap_box_downsampler_defines.svh"

module mipmap_box_downsampler import mbd_pkg::*; #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample_0,
	input  logic [SAMPLE_W-1:0] sample_1,
	input  logic [SAMPLE_W-1:0] sample_2,
	input  logic [SAMPLE_W-1:0] sample_3,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mip_0,
	output logic [SAMPLE_W-1:0] mip_1,
	output logic [SAMPLE_W-1:0] mip_2,
	output logic [SAMPLE_W-1:0] mip_3,
	output logic                last_pixel
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int EW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0] width_q, height_q;
	logic [CH_W-1:0]  chan_q;
	logic             wide_q;

	logic [EW-1:0]    width_ext, eff_w, ow, col_ext, colh_ext;
	logic [CFG_W-1:0] eff_h, oh, row_ext, rowh_ext;
	logic [CH_W-1:0]  n_ch;
	logic [LANES-1:0] lane_en;
	logic             w_one, h_one, emit, last, col_end, row_end;
	logic [CW-1:0]    col_q, col_half;
	logic [ROW_W-1:0] row_q;
	pix_t             samp, cur, left_q;
	logic             in_fire, adv;

	logic             valid_s1;
	ctl_t             ctl_s1, ctl_d;
	pix_t             cur_s1, left_s1;
	pix_t             rd_even, rd_odd, mip;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			chan_q   <= CH_W'(4);
			wide_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:     width_q  <= cfg_data;
				CFG_SRC_HEIGHT:    height_q <= cfg_data;
				CFG_CHANNEL_COUNT: chan_q   <= cfg_data[CH_W-1:0];
				CFG_WIDE_SAMPLES:  wide_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective geometry and channel count
	always_comb begin
		width_ext = EW'(width_q);
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
		if (height_q == '0) begin
			eff_h = CFG_W'(1);
		end else if (height_q > CFG_W'(HEIGHT_LIMIT)) begin
			eff_h = CFG_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = height_q;
		end
		ow = ((eff_w >> 1) == '0) ? EW'(1) : (eff_w >> 1);
		oh = ((eff_h >> 1) == '0) ? CFG_W'(1) : (eff_h >> 1);
		if (chan_q == '0) begin
			n_ch = CH_W'(1);
		end else if (chan_q > CH_W'(MAX_CHANNELS)) begin
			n_ch = CH_W'(MAX_CHANNELS);
		end else begin
			n_ch = chan_q;
		end
		for (int c = 0; c < LANES; c++) begin
			lane_en[c] = CH_W'(c) < n_ch;
		end
	end

	assign w_one = (eff_w == EW'(1));
	assign h_one = (eff_h == CFG_W'(1));

	// mask the incoming samples to the sample size and channel count
	assign samp = {sample_3, sample_2, sample_1, sample_0};
	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			if (!lane_en[c]) begin
				cur[c] = '0;
			end else if (wide_q) begin
				cur[c] = samp[c];
			end else begin
				cur[c] = {8'd0, samp[c][7:0]};
			end
		end
	end

	// position decode
	always_comb begin
		col_half = col_q >> 1;
		col_ext  = EW'(col_q);
		colh_ext = EW'(col_half);
		row_ext  = CFG_W'(row_q);
		rowh_ext = CFG_W'(row_q >> 1);
		emit     = (w_one || col_q[0]) && (h_one || row_q[0])
			&& (colh_ext < ow) && (rowh_ext < oh);
		last     = (colh_ext == ow - EW'(1)) && (rowh_ext == oh - CFG_W'(1));
		col_end  = (col_ext + EW'(1)) >= eff_w;
		row_end  = (row_ext + CFG_W'(1)) >= eff_h;
		ctl_d.last    = last;
		ctl_d.h_one   = h_one;
		ctl_d.w_one   = w_one;
		ctl_d.lane_en = lane_en;
	end

	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	// raster counters and previous pixel of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (in_fire) begin
			left_q <= cur;
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read stage: holds an emitting item while the line store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= emit;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1  <= ctl_d;
			cur_s1  <= cur;
			left_s1 <= left_q;
		end
	end

	// even rows fill the line store, every item reads the column pair
	mbd_line_store #(
		.DEPTH  (DEPTH),
		.AW     (AW),
		.LANE_N (MAX_CHANNELS)
	) u_line_store (
		.clk     (clk),
		.wr_en   (in_fire && !row_q[0]),
		.wr_odd  (col_q[0]),
		.wr_addr (AW'(col_half)),
		.wr_data (cur),
		.rd_en   (in_fire),
		.rd_addr (AW'(col_half)),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	mbd_reduce u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.cur_s1     (cur_s1),
		.left_s1    (left_s1),
		.rd_even    (rd_even),
		.rd_odd     (rd_odd),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mip        (mip),
		.last_pixel (last_pixel)
	);

	assign mip_0 = mip[0];
	assign mip_1 = mip[1];
	assign mip_2 = mip[2];
	assign mip_3 = mip[3];

	// checks
	`MBD_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(cur_s1) && $stable(ctl_s1))
	`MBD_ASSERT_NEXT(a_emit_load, clk, arst_n, in_fire && emit, valid_s1)
	`MBD_ASSERT_NOW(a_even_row_quiet, clk, arst_n, in_fire && !row_q[0] && !h_one, !emit)
	`MBD_ASSERT_NEXT(a_no_phantom_out, clk, arst_n, !out_valid && !valid_s1, !out_valid)

endmodule

// ===== sv/mbd_line_store.sv =====
module mbd_line_store import mbd_pkg::*; #(
	parameter int DEPTH  = 2048,
	parameter int AW     = 11,
	parameter int LANE_N = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          wr_odd,
	input  logic [AW-1:0] wr_addr,
	input  pix_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pix_t          rd_even,
	output pix_t          rd_odd
);

	// even and odd source columns live in separate banks, one read each per item
	logic [LANE_N-1:0][SAMPLE_W-1:0] mem_even [DEPTH];
	logic [LANE_N-1:0][SAMPLE_W-1:0] mem_odd  [DEPTH];
	logic [LANE_N-1:0][SAMPLE_W-1:0] even_q;
	logic [LANE_N-1:0][SAMPLE_W-1:0] odd_q;

	// even bank
	always_ff @(posedge clk) begin
		if (wr_en && !wr_odd) begin
			mem_even[wr_addr] <= wr_data[LANE_N-1:0];
		end
		if (rd_en) begin
			even_q <= mem_even[rd_addr];
		end
	end

	// odd bank
	always_ff @(posedge clk) begin
		if (wr_en && wr_odd) begin
			mem_odd[wr_addr] <= wr_data[LANE_N-1:0];
		end
		if (rd_en) begin
			odd_q <= mem_odd[rd_addr];
		end
	end

	// lanes above the stored count read as zero
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		if (g < LANE_N) begin : g_used
			assign rd_even[g] = even_q[g];
			assign rd_odd[g]  = odd_q[g];
		end else begin : g_unused
			assign rd_even[g] = '0;
			assign rd_odd[g]  = '0;
		end
	end

endmodule

// ===== sv/mbd_reduce.sv =====
module mbd_reduce import mbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  ctl_t                ctl_s1,
	input  pix_t                cur_s1,
	input  pix_t                left_s1,
	input  pix_t                rd_even,
	input  pix_t                rd_odd,
	output logic                adv,
	output logic                out_valid,
	input  logic                out_ready,
	output pix_t                mip,
	output logic                last_pixel
);

	pix_t                tl, tr, bl;
	logic [SAMPLE_W+1:0] sum [LANES];
	pix_t                avg;
	logic                out_valid_q;
	pix_t                mip_q;
	logic                last_q;

	// pick the 2x2 neighbours, folding in the single row and single column cases
	always_comb begin
		bl = ctl_s1.w_one ? cur_s1 : left_s1;
		if (ctl_s1.h_one) begin
			tl = bl;
			tr = cur_s1;
		end else begin
			tl = rd_even;
			tr = ctl_s1.w_one ? rd_even : rd_odd;
		end
	end

	// per-lane sum of four, truncated average
	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			sum[c] = (SAMPLE_W+2)'(tl[c]) + (SAMPLE_W+2)'(tr[c])
				+ (SAMPLE_W+2)'(bl[c]) + (SAMPLE_W+2)'(cur_s1[c]);
			avg[c] = ctl_s1.lane_en[c] ? sum[c][SAMPLE_W+1:2] : '0;
		end
	end

	assign adv = !out_valid_q || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			mip_q  <= avg;
			last_q <= ctl_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign mip        = mip_q;
	assign last_pixel = last_q;

endmodule

// ===== dv/mipmap_box_downsampler_tb.sv =====
`timescale 1ns / 1ps

module mipmap_box_downsampler_tb;
	import mbd_pkg::*;

	localparam int MAX_WIDTH   = 4096;
	localparam int CW          = $clog2(MAX_WIDTH);
	localparam int STALL_LIMIT = 2000;

	typedef enum {PIX_RANDOM, PIX_ONES, PIX_ZEROS, PIX_MIXED} pix_mode_t;

	typedef struct packed {
		pix_t mip;
		logic last;
	} mip_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample_0, sample_1, sample_2, sample_3;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] mip_0, mip_1, mip_2, mip_3;
	logic                last_pixel;

	// shadow of the configuration registers, reset values
	logic [CFG_W-1:0] width_reg  = 13'd1;
	logic [CFG_W-1:0] height_reg = 13'd1;
	logic [2:0]       chan_reg   = 3'd4;
	logic             wide_reg   = 1'b0;

	// shadow of the block state
	pix_t        line_mem [MAX_WIDTH];
	pix_t        left_pix = '0;
	int unsigned col_pos  = 0;
	int unsigned row_pos  = 0;

	mip_result_t pending_mips [$];
	int          mismatches   = 0;
	int          pixels_sent  = 0;
	int          idle_cycles  = 0;
	int          in_calm      = 0;
	int          out_calm     = 0;
	int          out_wait     = 0;

	mipmap_box_downsampler #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_CHANNELS(LANES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_0(sample_0),
		.sample_1(sample_1),
		.sample_2(sample_2),
		.sample_3(sample_3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mip_0(mip_0),
		.mip_1(mip_1),
		.mip_2(mip_2),
		.mip_3(mip_3),
		.last_pixel(last_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clamp a dimension register to its working range
	function automatic int unsigned eff_dim(input int unsigned v, input int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		case ($urandom_range(0, 9))
			5, 6, 7: return $urandom_range(1, 3);
			8: return $urandom_range(4, 8);
			9: return $urandom_range(9, 20);
			default: return 0;
		endcase
	endfunction

	function automatic pix_t make_pixel(input pix_mode_t mode);
		pix_t px;
		int c;
		for (c = 0; c < LANES; c++) begin
			case (mode)
				PIX_ONES: px[c] = '1;
				PIX_ZEROS: px[c] = '0;
				PIX_MIXED: begin
					case ($urandom_range(0, 5))
						0: px[c] = '0;
						1: px[c] = '1;
						2: px[c] = 16'h00FF;
						3: px[c] = 16'hFF00;
						default: px[c] = SAMPLE_W'($urandom_range(0, 16'hFFFF));
					endcase
				end
				default: px[c] = SAMPLE_W'($urandom_range(0, 16'hFFFF));
			endcase
		end
		return px;
	endfunction

	function automatic void apply_config(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
			CFG_SRC_WIDTH: width_reg = val;
			CFG_SRC_HEIGHT: height_reg = val;
			CFG_CHANNEL_COUNT: chan_reg = val[2:0];
			CFG_WIDE_SAMPLES: wide_reg = val[0];
			default: ;
		endcase
	endfunction

	// one source pixel through the 2x2 box filter, queueing the output pixel if any
	function automatic void predict_mip_pixel(input pix_t raw);
		int unsigned w, h, n, ow, oh, col, row, s;
		int c;
		pix_t cur, tl, tr, bl, br;
		mip_result_t res;
		logic [SAMPLE_W-1:0] smask;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, HEIGHT_LIMIT);
		n = eff_dim(chan_reg, LANES);
		ow = (w >> 1) != 0 ? (w >> 1) : 1;
		oh = (h >> 1) != 0 ? (h >> 1) : 1;
		smask = wide_reg ? 16'hFFFF : 16'h00FF;
		col = col_pos;
		row = row_pos;
		cur = '0;
		for (c = 0; c < LANES; c++)
			if (c < n)
				cur[c] = raw[c] & smask;

		// emit on odd row and odd column, or where that dimension is one
		if ((w == 1 || (col & 1) != 0) && (h == 1 || (row & 1) != 0) &&
				(col >> 1) < ow && (row >> 1) < oh) begin
			bl = (w == 1) ? cur : left_pix;
			br = cur;
			if (h == 1) begin
				tl = bl;
				tr = br;
			end else begin
				tl = line_mem[CW'((w == 1) ? col : col - 1)];
				tr = line_mem[CW'(col)];
			end
			res = '0;
			for (c = 0; c < LANES; c++) begin
				if (c < n) begin
					s = tl[c] + tr[c] + bl[c] + br[c];
					res.mip[c] = SAMPLE_W'(s >> 2);
				end
			end
			res.last = ((col >> 1) == ow - 1) && ((row >> 1) == oh - 1);
			pending_mips.push_back(res);
		end

		// even rows fill the line store
		if ((row & 1) == 0 && col < MAX_WIDTH)
			line_mem[CW'(col)] = cur;
		left_pix = cur;

		if (col + 1 >= w) begin
			col_pos = 0;
			row_pos = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col_pos = col + 1;
		end
	endfunction

	// prediction on accepted items, comparison on accepted results
	always @(posedge clk) begin
		pix_t got;
		mip_result_t want;
		int c;
		if (arst_n) begin
			if (cfg_we)
				apply_config(cfg_index, cfg_data);
			if (in_valid && in_ready)
				predict_mip_pixel({sample_3, sample_2, sample_1, sample_0});
			if (out_valid && out_ready) begin
				if (pending_mips.size() == 0) begin
					$error("unexpected item: mip_0 %h last_pixel %b", mip_0, last_pixel);
					mismatches++;
				end else begin
					want = pending_mips.pop_front();
					got = {mip_3, mip_2, mip_1, mip_0};
					for (c = 0; c < LANES; c++) begin
						if (got[c] !== want.mip[c]) begin
							$error("mip_%0d expected %h actual %h", c, want.mip[c], got[c]);
							mismatches++;
						end
					end
					if (last_pixel !== want.last) begin
						$error("last_pixel expected %b actual %b", want.last, last_pixel);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (out_wait > 0) begin
			out_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_wait = pick_gap(out_calm);
		end
	end

	task automatic send_pixel(input pix_t px);
		int gap;
		gap = pick_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_0 <= px[0];
		sample_1 <= px[1];
		sample_2 <= px[2];
		sample_3 <= px[3];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_sent++;
	endtask

	// all results in, then a few cycles for items that emit nothing
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_mips.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] wide);
		wait_drained();
		write_reg(CFG_SRC_WIDTH, w);
		write_reg(CFG_SRC_HEIGHT, h);
		write_reg(CFG_CHANNEL_COUNT, n);
		write_reg(CFG_WIDE_SAMPLES, wide);
		cfg_we <= 1'b0;
	endtask

	task automatic run_image(input int w, input int h, input int n, input int wide,
			input pix_mode_t mode);
		set_config(CFG_W'(w), CFG_W'(h), CFG_W'(n), CFG_W'(wide));
		repeat (eff_dim(w, MAX_WIDTH) * eff_dim(h, HEIGHT_LIMIT))
			send_pixel(make_pixel(mode));
	endtask

	function automatic int pick_dim();
		case ($urandom_range(0, 19))
			0: return 0;
			1, 2, 3: return $urandom_range(9, 24);
			4: return $urandom_range(25, 40);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int pick_channels();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 7);
		return $urandom_range(1, 4);
	endfunction

	// reset configuration: 1x1 source, each item is its own output pixel
	task automatic test_reset_defaults();
		send_pixel(make_pixel(PIX_ONES));
		send_pixel(make_pixel(PIX_ZEROS));
		send_pixel(make_pixel(PIX_RANDOM));
		send_pixel(make_pixel(PIX_MIXED));
	endtask

	task automatic test_sample_extremes();
		run_image(2, 2, 4, 1, PIX_ONES);
		run_image(2, 2, 4, 0, PIX_ONES);
		run_image(2, 2, 4, 1, PIX_ZEROS);
		run_image(3, 3, 4, 1, PIX_MIXED);
		run_image(4, 2, 4, 1, PIX_RANDOM);
	endtask

	// in-range counts and out-of-range codes that clamp
	task automatic test_channel_counts();
		int n;
		for (n = 0; n < 8; n++)
			run_image(2, 2, n, n % 2, PIX_RANDOM);
	endtask

	// unit and zero dimensions repeat the pixel or the row
	task automatic test_unit_dimensions();
		run_image(1, 1, 4, 1, PIX_MIXED);
		run_image(1, 5, 4, 1, PIX_MIXED);
		run_image(5, 1, 4, 0, PIX_MIXED);
		run_image(2, 1, 3, 1, PIX_MIXED);
		run_image(1, 2, 2, 1, PIX_MIXED);
		run_image(0, 0, 4, 1, PIX_MIXED);
		run_image(0, 3, 4, 1, PIX_MIXED);
		run_image(3, 0, 4, 1, PIX_MIXED);
	endtask

	// oversized codes clamp to the limits, partial rows and columns
	task automatic test_size_extremes();
		// single row with a width code above the limit
		set_config(13'd8191, 13'd1, 13'd2, 13'd1);
		repeat (20) send_pixel(make_pixel(PIX_RANDOM));
		// a narrower width ends the row and the image
		set_config(13'd2, 13'd1, 13'd2, 13'd1);
		send_pixel(make_pixel(PIX_RANDOM));
		// single column with a height code above the limit
		set_config(13'd1, 13'd8191, 13'd3, 13'd0);
		repeat (20) send_pixel(make_pixel(PIX_RANDOM));
		// a lower height ends the image
		set_config(13'd1, 13'd2, 13'd3, 13'd0);
		send_pixel(make_pixel(PIX_RANDOM));
	endtask

	// dimensions shrunk while an image is partly through
	task automatic test_mid_image_change();
		// width drops mid row: the next item ends the row
		set_config(4, 4, 4, 1);
		repeat (6) send_pixel(make_pixel(PIX_RANDOM));
		set_config(2, 4, 4, 1);
		repeat (5) send_pixel(make_pixel(PIX_RANDOM));
		// height drops at a row boundary: the next row ends the image
		set_config(2, 4, 4, 0);
		repeat (4) send_pixel(make_pixel(PIX_RANDOM));
		set_config(2, 2, 4, 0);
		repeat (2) send_pixel(make_pixel(PIX_RANDOM));
	endtask

	// random whole images, some reconfigured after an even number of rows
	task automatic test_random_images();
		int start, w, h, ew, eh, ew2, eh2, rows_done, rows_left;
		start = pixels_sent;
		while (pixels_sent < start + 700) begin
			if ($urandom_range(0, 5) == 0) begin
				w = pick_dim();
				h = $urandom_range(3, 12);
				ew = eff_dim(w, MAX_WIDTH);
				eh = eff_dim(h, HEIGHT_LIMIT);
				rows_done = 2 * $urandom_range(1, (eh - 1) / 2);
				set_config(CFG_W'(w), CFG_W'(h), CFG_W'(pick_channels()),
					CFG_W'($urandom_range(0, 1)));
				repeat (rows_done * ew) send_pixel(make_pixel(PIX_MIXED));
				w = pick_dim();
				h = pick_dim();
				ew2 = eff_dim(w, MAX_WIDTH);
				eh2 = eff_dim(h, HEIGHT_LIMIT);
				rows_left = (rows_done >= eh2) ? 1 : eh2 - rows_done;
				set_config(CFG_W'(w), CFG_W'(h), CFG_W'(pick_channels()),
					CFG_W'($urandom_range(0, 1)));
				repeat (rows_left * ew2) send_pixel(make_pixel(PIX_RANDOM));
			end else begin
				run_image(pick_dim(), pick_dim(), pick_channels(), $urandom_range(0, 1),
					$urandom_range(0, 1) ? PIX_RANDOM : PIX_MIXED);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SRC_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_0 = '0;
		sample_1 = '0;
		sample_2 = '0;
		sample_3 = '0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_sample_extremes();
		test_channel_counts();
		test_unit_dimensions();
		test_mid_image_change();
		test_size_extremes();
		test_random_images();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_mips.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
